// ===== rtl/upd_pkg.sv =====
// Shared character constants and helper functions for the URL percent decoder.
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Value of a hex digit in either case; bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    case (c) inside
      [8'h30:8'h39]: v = 5'(c - 8'h30);
      [8'h41:8'h46]: v = 5'(c - 8'h41 + 8'd10);
      [8'h61:8'h66]: v = 5'(c - 8'h61 + 8'd10);
      default:       v = 5'h10;
    endcase
    return v;
  endfunction

  // True for the escape values that are decoded.
  function automatic logic is_code(input logic [7:0] v);
    logic hit;
    hit = 1'b0;
    case (v) inside
      8'h20, 8'h21, 8'h22, 8'h23, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h2C,
      8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D, 8'h7B, 8'h7D:
        hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Plain byte: '+' turns into a space.
  function automatic logic [7:0] plain(input logic [7:0] b);
    return (b == CH_PLUS) ? CH_SPACE : b;
  endfunction

endpackage

// ===== rtl/url_percent_decoder.sv =====
// Top level of the URL percent decoder: decode logic, result queue and output register.
//
// Usage:
//   Input channel in_valid/in_ready carries one raw byte (in_byte) and a flag
//   (in_is_final) marking the last byte of a URL. Output channel
//   out_valid/out_ready carries decoded bytes (out_byte) with
//   out_end_of_string set on the last decoded byte of each URL.
//   Each accepted byte is decoded into zero to three results, which go into
//   a small result queue; the queue feeds the output register one result per
//   cycle unless the receiver stalls. A result is registered in the queue,
//   then in the output register, which raises out_valid. Throughput is one
//   byte per cycle while each byte yields at most one result and the receiver
//   keeps up; a byte with more results holds the input until its last result
//   moves to the output register. A '%' and the byte after it give no result
//   until the escape completes. When the receiver stalls, the output register
//   holds its item and the queue keeps its entries; a new byte is taken only
//   while the queue is empty or its last entry moves out. Reset (rst_n low,
//   synchronous) empties the queue and output register, clears the escape state.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end_of_string
);
  import upd_pkg::*;

  localparam logic [1:0] HC_NONE = 2'd0;
  localparam logic [1:0] HC_PCT  = 2'd1;
  localparam logic [1:0] HC_TWO  = 2'd2;

  localparam int PEND_DEPTH = 3;

  logic [1:0] hc_r, hc_nxt;
  logic [7:0] hf_r, hf_nxt;

  logic [7:0] pend_byte_r [PEND_DEPTH];
  logic       pend_last_r [PEND_DEPTH];
  logic [1:0] pend_cnt_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic [7:0] res_byte [PEND_DEPTH];
  logic       res_last [PEND_DEPTH];
  logic [1:0] res_cnt;

  logic       accept;
  logic       move;
  logic       out_free;
  logic [4:0] hx_hi;
  logic [4:0] hx_lo;
  logic [7:0] code_v;
  logic       hit;

  assign out_free = !out_valid_r || out_ready;
  assign move     = (pend_cnt_r != 2'd0) && out_free;
  assign in_ready = (pend_cnt_r == 2'd0) || ((pend_cnt_r == 2'd1) && move);
  assign accept   = in_valid && in_ready;

  assign hx_hi  = hex_val(hf_r);
  assign hx_lo  = hex_val(in_byte);
  assign code_v = {hx_hi[3:0], hx_lo[3:0]};
  assign hit    = !hx_hi[4] && !hx_lo[4] && is_code(code_v);

  // Decode one byte against the held escape state.
  always_comb begin
    hc_nxt = hc_r;
    hf_nxt = hf_r;
    res_cnt = 2'd0;
    for (int i = 0; i < PEND_DEPTH; i++) begin
      res_byte[i] = CH_PERCENT;
      res_last[i] = 1'b0;
    end
    case (hc_r)
      HC_PCT: begin
        if (in_is_final) begin
          hc_nxt      = HC_NONE;
          res_byte[1] = plain(in_byte);
          res_last[1] = 1'b1;
          res_cnt     = 2'd2;
        end else begin
          hf_nxt = in_byte;
          hc_nxt = HC_TWO;
        end
      end
      HC_TWO: begin
        hc_nxt = HC_NONE;
        if (hit) begin
          res_byte[0] = code_v;
          res_last[0] = in_is_final;
          res_cnt     = 2'd1;
        end else if (hf_r != CH_PERCENT) begin
          // literal '%', then both held bytes as fresh input
          res_byte[1] = plain(hf_r);
          if (in_byte == CH_PERCENT && !in_is_final) begin
            hc_nxt  = HC_PCT;
            res_cnt = 2'd2;
          end else begin
            res_byte[2] = plain(in_byte);
            res_last[2] = in_is_final;
            res_cnt     = 2'd3;
          end
        end else begin
          // held byte was itself a '%' and opens a new escape
          if (in_is_final) begin
            res_byte[2] = plain(in_byte);
            res_last[2] = 1'b1;
            res_cnt     = 2'd3;
          end else begin
            hf_nxt  = in_byte;
            hc_nxt  = HC_TWO;
            res_cnt = 2'd1;
          end
        end
      end
      default: begin
        if (in_byte == CH_PERCENT && !in_is_final) begin
          hc_nxt = HC_PCT;
        end else begin
          res_byte[0] = plain(in_byte);
          res_last[0] = in_is_final;
          res_cnt     = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= HC_NONE;
      hf_r <= 8'h00;
    end else if (accept) begin
      hc_r <= hc_nxt;
      hf_r <= hf_nxt;
    end
  end

  // Result queue: head at entry 0, shifts down as entries leave.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
    end else if (accept) begin
      pend_cnt_r <= res_cnt;
    end else if (move) begin
      pend_cnt_r <= pend_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PEND_DEPTH; i++) begin
        pend_byte_r[i] <= res_byte[i];
        pend_last_r[i] <= res_last[i];
      end
    end else if (move) begin
      for (int i = 0; i < PEND_DEPTH - 1; i++) begin
        pend_byte_r[i] <= pend_byte_r[i + 1];
        pend_last_r[i] <= pend_last_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte_r <= pend_byte_r[0];
      out_last_r <= pend_last_r[0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_end_of_string = out_last_r;

`ifndef NO_ASSERTIONS
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_is_final |=> hc_r == HC_NONE)
    else $error("escape state not cleared after final byte");

  a_hold_legal: assert property (@(posedge clk) disable iff (!rst_n)
    hc_r != 2'd3)
    else $error("illegal held count");

  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> pend_cnt_r <= 2'd1)
    else $error("input ready while queue holds more than one result");

  a_queue_feeds_out: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid_r)
    else $error("queue entry left without reaching output register");
`endif

endmodule

// ===== tb/url_decode_checker.sv =====
// Checker for the URL percent decoder: byte-level decode prediction and result compare.
`timescale 1ns / 100ps

module url_decode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_final,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_end_of_string,
  output int         fail_count,
  output int         pending,
  output int         bytes_in,
  output int         bytes_out
);
  import upd_pkg::*;

  typedef enum logic [1:0] {HOLD_NONE, HOLD_PCT, HOLD_DIGIT} hold_t;
  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } dec_t;

  localparam int MAX_PER_BYTE = 3;

  hold_t      held_state = HOLD_NONE;
  logic [7:0] held_digit = 8'h00;
  dec_t       decoded_q[$];

  function automatic dec_t mk_dec(input logic [7:0] chr, input logic last);
    dec_t d;
    d.chr  = chr;
    d.last = last;
    return d;
  endfunction

  // -1 when the byte is not a hex digit
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    return -1;
  endfunction

  function automatic logic listed_escape(input logic [7:0] v);
    case (v)
      8'h20, 8'h21, 8'h22, 8'h23, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h2C,
      8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D, 8'h7B, 8'h7D:
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic queue_decoded(input logic [7:0] chr, input logic last, inout int made);
    if (made < MAX_PER_BYTE) begin
      decoded_q = {decoded_q, mk_dec(chr, last)};
      made++;
    end
  endtask

  // Bytes that fall out of a failed escape are fed back in front of the work list,
  // in order, so they are decoded before anything else.
  task automatic predict_item(input logic [7:0] b, input logic fin);
    dec_t       work[$];
    dec_t       cur;
    int         made;
    int         hi;
    int         lo;
    logic [7:0] val;
    made = 0;
    work = {work, mk_dec(b, fin)};
    while (work.size() > 0) begin
      cur = work.pop_front();
      case (held_state)
        HOLD_NONE: begin
          if (cur.chr == CH_PERCENT && !cur.last)
            held_state = HOLD_PCT;
          else
            queue_decoded((cur.chr == CH_PLUS) ? CH_SPACE : cur.chr, cur.last, made);
        end
        HOLD_PCT: begin
          if (cur.last) begin
            // percent too close to the end: literal, then the byte itself
            held_state = HOLD_NONE;
            queue_decoded(CH_PERCENT, 1'b0, made);
            work.push_front(cur);
          end else begin
            held_digit = cur.chr;
            held_state = HOLD_DIGIT;
          end
        end
        default: begin
          held_state = HOLD_NONE;
          hi = nibble_of(held_digit);
          lo = nibble_of(cur.chr);
          val = 8'((hi << 4) | lo);
          if (hi >= 0 && lo >= 0 && listed_escape(val)) begin
            queue_decoded(val, cur.last, made);
          end else begin
            queue_decoded(CH_PERCENT, 1'b0, made);
            work.push_front(cur);
            work.push_front(mk_dec(held_digit, 1'b0));
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    dec_t want;
    if (!rst_n) begin
      held_state = HOLD_NONE;
      held_digit = 8'h00;
      decoded_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_byte, in_is_final);
        bytes_in++;
      end
      if (out_valid && out_ready) begin
        bytes_out++;
        if (decoded_q.size() == 0) begin
          $error("unexpected item: out_byte %h out_end_of_string %b", out_byte,
                 out_end_of_string);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.chr) begin
            $error("out_byte mismatch: expected %h, got %h", want.chr, out_byte);
            fail_count++;
          end
          if (out_end_of_string !== want.last) begin
            $error("out_end_of_string mismatch: expected %b, got %b", want.last,
                   out_end_of_string);
            fail_count++;
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

// ===== tb/url_percent_decoder_tb.sv =====
// Top of the URL percent decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module url_percent_decoder_tb;
  import upd_pkg::*;

  localparam int TOTAL_BYTES    = 210;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 3000;
  // escape values that decode, first entry in the top byte
  localparam logic [21*8-1:0] ESCAPES = {
    8'h20, 8'h21, 8'h22, 8'h23, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h2C,
    8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D, 8'h7B, 8'h7D
  };

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte     = 8'h00;
  logic       in_is_final = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] out_byte;
  logic       out_end_of_string;
  logic       hold_req    = 1'b0;

  int fail_count;
  int pending;
  int bytes_in;
  int bytes_out;

  int         sent_count   = 0;
  int         url_count    = 0;
  int         burst_left   = 0;
  bit         steady       = 1'b0;
  logic [7:0] url_bytes[$];

  always #4 clk = ~clk;

  url_percent_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_is_final      (in_is_final),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_end_of_string(out_end_of_string)
  );

  url_decode_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_is_final      (in_is_final),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_end_of_string(out_end_of_string),
    .fail_count       (fail_count),
    .pending          (pending),
    .bytes_in         (bytes_in),
    .bytes_out        (bytes_out)
  );

  // Receiver: windows of random stall density, plus one long hold-off on request.
  int hold_left  = 0;
  bit hold_taken = 1'b0;
  int win_left   = 0;
  int stall_pct  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (win_left == 0) begin
        win_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end else begin
        win_left--;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken, or later when a random idle gap follows it.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    in_valid    <= 1'b1;
    in_byte     <= b;
    in_is_final <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    if (steady) begin
      burst_left = 0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(8'(s[i]), i == s.len() - 1);
    url_count++;
  endtask

  task automatic send_url();
    for (int i = 0; i < url_bytes.size(); i++)
      send_byte(url_bytes[i], i == url_bytes.size() - 1);
    url_count++;
  endtask

  // Input goes quiet until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    url_bytes = {url_bytes, b};
  endtask

  task automatic add_token();
    logic [7:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: add_byte(8'($urandom_range(8'h21, 8'h7E)));
      3:       add_byte(CH_PLUS);
      4, 5: begin
        v = ESCAPES[(20 - $urandom_range(0, 20)) * 8 +: 8];
        add_byte(CH_PERCENT);
        add_byte(hex_char(v[7:4], 1'($urandom_range(0, 1))));
        add_byte(hex_char(v[3:0], 1'($urandom_range(0, 1))));
      end
      6: begin
        // hex pair, mostly not a listed escape
        add_byte(CH_PERCENT);
        add_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        add_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
      7: begin
        add_byte(CH_PERCENT);
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
      end
      8:       add_byte(CH_PERCENT);
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic build_url();
    int n;
    url_bytes.delete();
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) add_token();
    end
  endtask

  initial begin
    bit hold_asked;
    bit paused;
    int steady_urls;
    hold_asked  = 1'b0;
    paused      = 1'b0;
    steady_urls = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, plus to space, both hex cases, bad escapes,
    // percent close to the end of a string
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_PLUS, 1'b1);
    url_count += 2;
    send_text("%20%7d%2B%2f");
    send_text("%41%G%x");
    send_text("%");
    send_text("%2");
    wait_drained();

    while (sent_count < TOTAL_BYTES) begin
      if (!hold_asked && sent_count >= 100) begin
        // long receiver hold-off while input is offered at full rate
        hold_asked  = 1'b1;
        hold_req   <= 1'b1;
        steady_urls = 4;
      end
      if (!paused && sent_count >= 160) begin
        paused = 1'b1;
        wait_drained();
      end
      build_url();
      steady = (steady_urls > 0) || ($urandom_range(0, 4) == 0);
      if (steady_urls > 0) steady_urls--;
      send_url();
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Covered %0d bytes in %0d URL strings, %0d decoded bytes compared", bytes_in,
             url_count, bytes_out);
    $display("Mix: valid and invalid escapes, mixed-case hex, plus signs, noise bytes, stalls");
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
